FILE: rtl/rob_pkg.sv
`default_nettype none

package rob_pkg;

    localparam int DEPTH    = 16;
    localparam int TAG_BITS = 16;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);

    localparam logic [1:0] KIND_PUSH    = 2'd0;
    localparam logic [1:0] KIND_RETIRE  = 2'd1;
    localparam logic [1:0] KIND_FORWARD = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_BLOCKED = 2'd2;
    localparam logic [1:0] ST_NOMATCH = 2'd3;

    typedef struct packed {
        logic load;
        logic exec;
        logic fin;
    } rob_cmd_t;

    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                  input logic [IDX_W-1:0] b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (IDX_W+1)'(DEPTH))
        begin
            s = s - (IDX_W+1)'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] ring_dist(input logic [IDX_W-1:0] i,
                                                   input logic [IDX_W-1:0] h);
        logic [IDX_W:0] s;
        s = {1'b0, i} + (IDX_W+1)'(DEPTH) - {1'b0, h};
        if (s >= (IDX_W+1)'(DEPTH))
        begin
            s = s - (IDX_W+1)'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rob_ctrl.sv
`default_nettype none

module rob_ctrl
    import rob_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    output rob_cmd_t      cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    assign cmd.load = in_valid && in_ready;
    assign cmd.exec = (state_reg == S_EXEC);
    assign cmd.fin  = (state_reg == S_FIN) && slot_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.fin)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rob_dp.sv
`default_nettype none

module rob_dp
    import rob_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rob_cmd_t           cmd,
    input  wire logic [1:0]         kind,
    input  wire logic [15:0]        pc,
    input  wire logic signed [31:0] value,
    input  wire logic               ready_req,
    output logic [1:0]              status,
    output logic                    retired_valid,
    output logic [15:0]             retired_pc,
    output logic signed [31:0]      retired_value,
    output logic [CNT_W-1:0]        occupancy,
    output logic                    is_full,
    output logic                    is_empty
);

    logic [1:0]          kind_reg;
    logic [TAG_BITS-1:0] tag_in_reg;
    logic [31:0]         val_in_reg;
    logic                rdy_in_reg;

    logic [TAG_BITS-1:0] tag_reg [DEPTH];
    logic [31:0]         value_mem [DEPTH];
    logic [31:0]         rd_data_reg;
    logic [DEPTH-1:0]    done_reg;
    logic [IDX_W-1:0]    head_reg;
    logic [IDX_W-1:0]    tail_reg;
    logic [CNT_W-1:0]    count_reg;

    logic [DEPTH-1:0]    match_reg;
    logic [1:0]          st_reg;
    logic                rv_reg;
    logic [TAG_BITS-1:0] ret_tag_reg;

    logic [1:0]          status_reg;
    logic                retired_valid_reg;
    logic [15:0]         retired_pc_reg;
    logic [31:0]         retired_value_reg;
    logic [CNT_W-1:0]    occupancy_reg;

    logic [DEPTH-1:0]    match_next;
    logic                can_push;
    logic                can_retire;
    logic                hit;
    logic [IDX_W-1:0]    hit_idx;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [31:0]         wr_data;

    assign can_push   = (count_reg < CNT_W'(DEPTH));
    assign can_retire = (count_reg != '0) && done_reg[head_reg];

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            match_next[i] = (tag_reg[i] == tag_in_reg)
                && (CNT_W'(ring_dist(IDX_W'(i), head_reg)) < count_reg);
        end
    end

    always_comb
    begin
        hit     = 1'b0;
        hit_idx = head_reg;
        for (int k = DEPTH - 1; k >= 0; k--)
        begin
            if (match_reg[ring_add(head_reg, IDX_W'(k))])
            begin
                hit     = 1'b1;
                hit_idx = ring_add(head_reg, IDX_W'(k));
            end
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = tail_reg;
        wr_data = val_in_reg;
        if (cmd.exec && kind_reg == KIND_PUSH && can_push)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.fin && kind_reg == KIND_FORWARD && hit)
        begin
            wr_en   = 1'b1;
            wr_addr = hit_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            value_mem[wr_addr] <= wr_data;
        end
        if (cmd.exec && kind_reg == KIND_RETIRE)
        begin
            rd_data_reg <= value_mem[head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg   <= kind;
            tag_in_reg <= TAG_BITS'(pc);
            val_in_reg <= value;
            rdy_in_reg <= ready_req;
        end
        if (cmd.exec)
        begin
            match_reg   <= match_next;
            ret_tag_reg <= tag_reg[head_reg];
            if (kind_reg == KIND_PUSH && can_push)
            begin
                tag_reg[tail_reg] <= tag_in_reg;
            end
        end
        if (cmd.fin)
        begin
            status_reg        <= (kind_reg == KIND_FORWARD)
                                 ? (hit ? ST_OK : ST_NOMATCH) : st_reg;
            retired_valid_reg <= rv_reg;
            retired_pc_reg    <= rv_reg ? 16'(ret_tag_reg) : 16'd0;
            retired_value_reg <= rv_reg ? rd_data_reg : 32'd0;
            occupancy_reg     <= count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            st_reg    <= ST_OK;
            rv_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                st_reg <= ST_OK;
                rv_reg <= 1'b0;
                case (kind_reg)
                    KIND_PUSH:
                    begin
                        if (can_push)
                        begin
                            done_reg[tail_reg] <= rdy_in_reg;
                            tail_reg           <= ring_add(tail_reg, IDX_W'(1));
                            count_reg          <= count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            st_reg <= ST_FULL;
                        end
                    end
                    KIND_RETIRE:
                    begin
                        if (can_retire)
                        begin
                            rv_reg             <= 1'b1;
                            done_reg[head_reg] <= 1'b0;
                            head_reg           <= ring_add(head_reg, IDX_W'(1));
                            count_reg          <= count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            st_reg <= ST_BLOCKED;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.fin && kind_reg == KIND_FORWARD && hit)
            begin
                done_reg[hit_idx] <= 1'b1;
            end
        end
    end

    assign status        = status_reg;
    assign retired_valid = retired_valid_reg;
    assign retired_pc    = retired_pc_reg;
    assign retired_value = retired_value_reg;
    assign occupancy     = occupancy_reg;
    assign is_full       = (occupancy_reg == CNT_W'(DEPTH));
    assign is_empty      = (occupancy_reg == '0);

endmodule

`default_nettype wire

FILE: rtl/reorder_buffer_pc_tagged_core.sv
`default_nettype none

// In-order reorder buffer of DEPTH entries kept as a ring, each entry holding a
// pc tag, a 32-bit result and a done flag. kind selects push (append at tail,
// dropped when full), retire (pop the head only when it is done) or forward
// (write the result into the oldest held entry whose tag matches and mark it
// done). One item is in work at a time: a new item is taken only once the
// result of the last one is loaded into the output register and the
// controller is back in idle. The three steps are set by the controller
// sequence: capture the item, update the ring (tag compare across all held
// entries runs in parallel and is registered, the head result is read from
// the value memory), then pick the oldest match and load the output
// register. A waiting result holds the block in its final step until the
// output register can be reloaded. Kind 3 changes nothing and reports
// status OK.
module reorder_buffer_pc_tagged_core
    import rob_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         kind,
    input  wire logic [15:0]        pc,
    input  wire logic signed [31:0] value,
    input  wire logic               ready_req,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              status,
    output logic                    retired_valid,
    output logic [15:0]             retired_pc,
    output logic signed [31:0]      retired_value,
    output logic [CNT_W-1:0]        occupancy,
    output logic                    is_full,
    output logic                    is_empty
);

    rob_cmd_t cmd;

    rob_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    rob_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .kind          (kind),
        .pc            (pc),
        .value         (value),
        .ready_req     (ready_req),
        .status        (status),
        .retired_valid (retired_valid),
        .retired_pc    (retired_pc),
        .retired_value (retired_value),
        .occupancy     (occupancy),
        .is_full       (is_full),
        .is_empty      (is_empty)
    );

endmodule

`default_nettype wire

FILE: rtl/rob_checker.sv
`default_nettype none

module rob_checker
    import rob_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic [1:0]         status,
    input  wire logic               retired_valid,
    input  wire logic [15:0]        retired_pc,
    input  wire logic signed [31:0] retired_value,
    input  wire logic [CNT_W-1:0]   occupancy,
    input  wire logic               is_full,
    input  wire logic               is_empty
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(occupancy) && $stable(retired_value))
        else $error("result changed while stalled");

    a_retire_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && retired_valid |-> status == ST_OK && !is_full)
        else $error("retire reported with bad status or full ring");

    a_no_retire_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !retired_valid |-> retired_pc == 16'd0 && retired_value == 32'sd0)
        else $error("retire fields nonzero without retirement");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_full == (occupancy == CNT_W'(DEPTH)))
            && (is_empty == (occupancy == '0)) && occupancy <= CNT_W'(DEPTH))
        else $error("occupancy flags inconsistent");

endmodule

bind reorder_buffer_pc_tagged_core rob_checker u_rob_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .retired_valid (retired_valid),
    .retired_pc    (retired_pc),
    .retired_value (retired_value),
    .occupancy     (occupancy),
    .is_full       (is_full),
    .is_empty      (is_empty)
);

`default_nettype wire

FILE: verif/tb.sv
module tb;
    import rob_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]       status;
        logic             retired_valid;
        logic [15:0]      retired_pc;
        logic [31:0]      retired_value;
        logic [CNT_W-1:0] occupancy;
        logic             is_full;
        logic             is_empty;
    } rob_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [1:0]              kind;
    logic [15:0]             pc;
    logic signed [31:0]      value;
    logic                    ready_req;
    logic                    out_valid;
    logic                    out_ready;
    logic [1:0]              status;
    logic                    retired_valid;
    logic [15:0]             retired_pc;
    logic signed [31:0]      retired_value;
    logic [CNT_W-1:0]        occupancy;
    logic                    is_full;
    logic                    is_empty;

    rob_result_t pending_results[$];

    logic [15:0] ring_tag [DEPTH];
    logic [31:0] ring_value [DEPTH];
    logic        ring_done [DEPTH];
    int          ring_head = 0;
    int          ring_tail = 0;
    int          ring_count = 0;

    int send_calm = 0;
    int recv_calm = 0;
    bit mismatch_seen = 1'b0;

    reorder_buffer_pc_tagged_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .pc            (pc),
        .value         (value),
        .ready_req     (ready_req),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .retired_valid (retired_valid),
        .retired_pc    (retired_pc),
        .retired_value (retired_value),
        .occupancy     (occupancy),
        .is_full       (is_full),
        .is_empty      (is_empty)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic rob_result_t predict_rob(input logic [1:0] k, input logic [15:0] p,
                                                input logic [31:0] v, input logic r);
        rob_result_t res;
        int          idx;
        bit          hit;
        res = '0;
        res.status = ST_OK;
        case (k)
            KIND_PUSH:
            begin
                if (ring_count >= DEPTH)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    ring_tag[ring_tail]   = p;
                    ring_value[ring_tail] = v;
                    ring_done[ring_tail]  = r;
                    ring_tail = (ring_tail + 1) % DEPTH;
                    ring_count++;
                end
            end
            KIND_RETIRE:
            begin
                if (ring_count == 0 || !ring_done[ring_head])
                begin
                    res.status = ST_BLOCKED;
                end
                else
                begin
                    res.retired_valid = 1'b1;
                    res.retired_pc    = ring_tag[ring_head];
                    res.retired_value = ring_value[ring_head];
                    ring_done[ring_head] = 1'b0;
                    ring_head = (ring_head + 1) % DEPTH;
                    ring_count--;
                end
            end
            KIND_FORWARD:
            begin
                hit = 1'b0;
                for (int n = 0; n < ring_count && !hit; n++)
                begin
                    idx = (ring_head + n) % DEPTH;
                    if (ring_tag[idx] == p)
                    begin
                        ring_value[idx] = v;
                        ring_done[idx]  = 1'b1;
                        hit = 1'b1;
                    end
                end
                if (!hit)
                begin
                    res.status = ST_NOMATCH;
                end
            end
            default:
            begin
            end
        endcase
        res.occupancy = CNT_W'(ring_count);
        res.is_full   = (ring_count == DEPTH);
        res.is_empty  = (ring_count == 0);
        return res;
    endfunction

    function automatic int pick_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    function automatic logic [15:0] rand_pc();
        if ($urandom_range(0, 3) == 0)
        begin
            return 16'($urandom_range(0, 7));
        end
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] held_tag();
        int n;
        n = $urandom_range(0, 1) ? 0 : $urandom_range(0, ring_count - 1);
        return ring_tag[(ring_head + n) % DEPTH];
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            mismatch_seen = 1'b1;
        end
    endfunction

    task automatic send_item(input logic [1:0] k, input logic [15:0] p,
                             input logic [31:0] v, input logic r);
        int gap;
        gap = pick_gap(send_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        pc        <= p;
        value     <= v;
        ready_req <= r;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        pending_results.push_back(predict_rob(k, p, v, r));
    endtask

    task automatic test_directed();
        send_item(KIND_RETIRE,  16'h0000, 32'h0000_0000, 1'b0);
        send_item(KIND_FORWARD, 16'h1234, 32'h1111_2222, 1'b0);
        send_item(KIND_UNUSED,  16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        send_item(KIND_PUSH,    16'h0000, 32'h8000_0000, 1'b0);
        send_item(KIND_PUSH,    16'hFFFF, 32'h7FFF_FFFF, 1'b1);
        send_item(KIND_PUSH,    16'h0000, 32'h0000_0000, 1'b0);
        send_item(KIND_RETIRE,  16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        send_item(KIND_FORWARD, 16'h0000, 32'hFFFF_FFFF, 1'b0);
        send_item(KIND_FORWARD, 16'h0000, 32'h0000_0001, 1'b1);
        send_item(KIND_FORWARD, 16'hABCD, 32'h5A5A_5A5A, 1'b0);
        send_item(KIND_UNUSED,  16'h0000, 32'h0000_0000, 1'b0);
        send_item(KIND_RETIRE,  16'h0000, 32'h0000_0000, 1'b0);
        send_item(KIND_RETIRE,  16'h0000, 32'h0000_0000, 1'b0);
        send_item(KIND_RETIRE,  16'h0000, 32'h0000_0000, 1'b0);
        send_item(KIND_FORWARD, 16'h0000, 32'h5555_AAAA, 1'b1);
        send_item(KIND_RETIRE,  16'h0000, 32'h0000_0000, 1'b0);
        send_item(KIND_UNUSED,  16'h5555, 32'hAAAA_5555, 1'b0);
    endtask

    task automatic test_fill_and_wrap(input int rounds);
        for (int rnd = 0; rnd < rounds; rnd++)
        begin
            while (ring_count < DEPTH)
            begin
                send_item(KIND_PUSH, rand_pc(), $urandom, 1'($urandom));
            end
            send_item(KIND_PUSH, rand_pc(), $urandom, 1'b1);
            send_item(KIND_PUSH, rand_pc(), $urandom, 1'b0);
            while (ring_count > 0)
            begin
                if (!ring_done[ring_head])
                begin
                    send_item(KIND_FORWARD, ring_tag[ring_head], $urandom, 1'($urandom));
                end
                send_item(KIND_RETIRE, 16'($urandom), $urandom, 1'($urandom));
            end
            send_item(KIND_RETIRE, 16'($urandom), $urandom, 1'($urandom));
            // shift the ring start so the next fill wraps
            repeat ($urandom_range(1, DEPTH - 1))
            begin
                send_item(KIND_PUSH, rand_pc(), $urandom, 1'b1);
                send_item(KIND_RETIRE, 16'($urandom), $urandom, 1'($urandom));
            end
        end
    endtask

    task automatic test_random_traffic(input int n_items);
        int          phase;
        int          roll;
        int          push_pct;
        int          fwd_pct;
        logic [15:0] p;
        phase = 0;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 40 == 0)
            begin
                phase = $urandom_range(0, 2);
            end
            push_pct = (phase == 0) ? 60 : (phase == 1) ? 15 : 33;
            fwd_pct  = (phase == 0) ? 25 : (phase == 1) ? 40 : 33;
            roll = $urandom_range(0, 99);
            if (roll < 2)
            begin
                send_item(KIND_UNUSED, 16'($urandom), $urandom, 1'($urandom));
            end
            else if (roll < 2 + push_pct)
            begin
                send_item(KIND_PUSH, rand_pc(), $urandom, 1'($urandom));
            end
            else if (roll < 2 + push_pct + fwd_pct)
            begin
                p = (ring_count > 0 && $urandom_range(0, 4) != 0) ? held_tag() : rand_pc();
                send_item(KIND_FORWARD, p, $urandom, 1'($urandom));
            end
            else
            begin
                send_item(KIND_RETIRE, 16'($urandom), $urandom, 1'($urandom));
            end
        end
    endtask

    initial
    begin : result_check
        int          stall;
        rob_result_t want;
        out_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = pick_gap(recv_calm);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            if (pending_results.size() == 0)
            begin
                $error("result with no item pending");
                mismatch_seen = 1'b1;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(status));
                check_field("retired_valid", 32'(want.retired_valid), 32'(retired_valid));
                check_field("retired_pc", 32'(want.retired_pc), 32'(retired_pc));
                check_field("retired_value", want.retired_value, retired_value);
                check_field("occupancy", 32'(want.occupancy), 32'(occupancy));
                check_field("is_full", 32'(want.is_full), 32'(is_full));
                check_field("is_empty", 32'(want.is_empty), 32'(is_empty));
            end
        end
    end

    initial
    begin : stimulus
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        kind      <= KIND_PUSH;
        pc        <= '0;
        value     <= '0;
        ready_req <= 1'b0;
        for (int n = 0; n < DEPTH; n++)
        begin
            ring_done[n] = 1'b0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_fill_and_wrap(2);
        test_random_traffic(1550);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (!mismatch_seen)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("tb failed");
        end
        $finish;
    end

    initial
    begin : watchdog
        #5000000;
        $display("tb failed");
        $finish;
    end

endmodule
